// ===== hw/rtl/bgiou_pkg.sv =====
// Shared constants of the box pair GIoU block.
`default_nettype none
package bgiou_pkg;
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF = 16;
endpackage
`default_nettype wire

// ===== hw/rtl/bgiou_stream_if.sv =====
// Valid/ready channel carrying one payload of configurable width.
`default_nettype none
interface bgiou_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bgiou_div_cell.sv =====
// One restoring division step of the pipelined fraction divider chain.
`default_nettype none
module bgiou_div_cell #(
    parameter int DW = 33,
    parameter int QW = 17
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [DW-1:0] rem_in,
    input  wire logic [DW-1:0] den_in,
    input  wire logic [QW-1:0] quo_in,
    output logic [DW-1:0]      rem_out,
    output logic [DW-1:0]      den_out,
    output logic [QW-1:0]      quo_out
);
    logic [DW:0] shifted;
    logic        take;

    assign shifted = {rem_in, 1'b0};
    assign take    = shifted >= {1'b0, den_in};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out <= take ? DW'(shifted - {1'b0, den_in}) : shifted[DW-1:0];
            den_out <= den_in;
            quo_out <= {quo_in[QW-2:0], take};
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/bgiou_divider.sv =====
// Chain of division cells giving floor(num * 2^F / den) for num <= den.
`default_nettype none
module bgiou_divider #(
    parameter int DW = 33,
    parameter int F  = 16
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [DW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic [F:0]         quo
);
    logic [DW-1:0] rem_s [F+1];
    logic [DW-1:0] den_s [F+1];
    logic [F:0]    quo_s [F+1];

    logic [DW-1:0] rem0_reg;
    logic [DW-1:0] den0_reg;
    logic [F:0]    quo0_reg;

    // The integer part is one bit since num never exceeds den.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem0_reg <= (num >= den) ? DW'(num - den) : num;
            den0_reg <= den;
            quo0_reg <= (F+1)'(num >= den);
        end
    end

    assign rem_s[0] = rem0_reg;
    assign den_s[0] = den0_reg;
    assign quo_s[0] = quo0_reg;

    for (genvar i = 0; i < F; i++)
    begin : g_cell
        bgiou_div_cell #(.DW(DW), .QW(F+1)) u_cell (
            .clk(clk), .en(en),
            .rem_in(rem_s[i]), .den_in(den_s[i]), .quo_in(quo_s[i]),
            .rem_out(rem_s[i+1]), .den_out(den_s[i+1]), .quo_out(quo_s[i+1])
        );
    end

    assign quo = quo_s[F];
endmodule
`default_nettype wire

// ===== hw/rtl/box_pair_generalized_iou.sv =====
// Top level of the box pair generalised intersection-over-union block.
// One box pair is taken per cycle while the output is not stalled. The
// pipeline is a subtract stage, a multiply stage, a union stage and the
// integer bit, followed by the two divider chains of one cell per fraction
// bit and then the output register. The whole pipeline advances when the
// output register is empty or being taken, so a stalled output holds every
// stage.
`default_nettype none
module box_pair_generalized_iou #(
    parameter int COORD_BITS = bgiou_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = bgiou_pkg::FRAC_BITS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    bgiou_stream_if.sink   in_ch,
    bgiou_stream_if.source out_ch
);
    import bgiou_pkg::*;

    localparam int CW    = COORD_BITS;
    localparam int AW    = 2 * CW;
    localparam int UW    = AW + 1;
    localparam int LAT   = FRAC_BITS + 5;
    localparam int OUT_W = (FRAC_BITS + 1) + UW + (FRAC_BITS + 2) + 1;

    logic [CW-1:0] al, at, ar, ab, bl, bt, br, bb;
    assign {al, at, ar, ab, bl, bt, br, bb} = in_ch.data;

    logic adv;
    logic [LAT-1:0] vld_reg;
    assign adv = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = adv;

    // Stage 1: side lengths.
    logic [CW-1:0] aw_reg, ah_reg, bw_reg, bh_reg, iw_reg, ih_reg, cw_reg, ch_reg;
    logic          bad1_reg;
    logic [CW-1:0] ix0, iy0, ix1, iy1, ex0, ey0, ex1, ey1;
    assign ix0 = (al > bl) ? al : bl;
    assign iy0 = (at > bt) ? at : bt;
    assign ix1 = (ar < br) ? ar : br;
    assign iy1 = (ab < bb) ? ab : bb;
    assign ex0 = (al < bl) ? al : bl;
    assign ey0 = (at < bt) ? at : bt;
    assign ex1 = (ar > br) ? ar : br;
    assign ey1 = (ab > bb) ? ab : bb;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bad1_reg <= (ar < al) || (ab < at) || (br < bl) || (bb < bt);
            aw_reg <= ar - al;
            ah_reg <= ab - at;
            bw_reg <= br - bl;
            bh_reg <= bb - bt;
            iw_reg <= (ix1 > ix0) ? ix1 - ix0 : '0;
            ih_reg <= (iy1 > iy0) ? iy1 - iy0 : '0;
            cw_reg <= ex1 - ex0;
            ch_reg <= ey1 - ey0;
        end
    end

    // Stage 2: areas.
    logic [AW-1:0] area_a_reg, area_b_reg, inter_reg, encl_reg;
    logic          bad2_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bad2_reg   <= bad1_reg;
            area_a_reg <= aw_reg * ah_reg;
            area_b_reg <= bw_reg * bh_reg;
            inter_reg  <= iw_reg * ih_reg;
            encl_reg   <= cw_reg * ch_reg;
        end
    end

    // Stage 3: union and the empty part of the enclosing box.
    logic [UW-1:0] uni_reg, encl3_reg, empty_reg, inter3_reg;
    logic          bad3_reg;
    logic [UW-1:0] uni_next;
    assign uni_next = UW'(area_a_reg) + UW'(area_b_reg) - UW'(inter_reg);
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            uni_reg    <= uni_next;
            encl3_reg  <= UW'(encl_reg);
            empty_reg  <= UW'(encl_reg) - uni_next;
            inter3_reg <= UW'(inter_reg);
            bad3_reg   <= bad2_reg || (uni_next == '0) || (encl_reg == '0);
        end
    end

    // Dividers; the malformed case may feed a zero divisor, masked later.
    logic [FRAC_BITS:0] iou_q, empty_q;
    bgiou_divider #(.DW(UW), .F(FRAC_BITS)) u_div_iou (
        .clk(clk), .en(adv), .num(inter3_reg), .den(uni_reg), .quo(iou_q)
    );
    bgiou_divider #(.DW(UW), .F(FRAC_BITS)) u_div_empty (
        .clk(clk), .en(adv), .num(empty_reg), .den(encl3_reg), .quo(empty_q)
    );

    // Side payload delay line matching the divider depth.
    localparam int DL = FRAC_BITS + 1;
    logic [UW-1:0] uni_d [DL];
    logic          bad_d [DL];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            uni_d[0]   <= uni_reg;
            bad_d[0]   <= bad3_reg;
            for (int i = 1; i < DL; i++)
            begin
                uni_d[i]   <= uni_d[i-1];
                bad_d[i]   <= bad_d[i-1];
            end
        end
    end

    // bad2 is one stage older than bad3; realign the malformed flag.
    logic malformed;
    logic bad_mal_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bad_mal_reg <= bad2_reg;
        end
    end
    logic [DL-1:0] mal_line_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mal_line_reg <= {mal_line_reg[DL-2:0], bad_mal_reg};
        end
    end
    assign malformed = mal_line_reg[DL-1];

    logic                   inv;
    logic [FRAC_BITS:0]     iou_v;
    logic [FRAC_BITS+1:0]   giou_v;
    logic [UW-1:0]          uni_v;
    assign inv    = bad_d[DL-1];
    assign iou_v  = inv ? '0 : iou_q;
    assign giou_v = inv ? '0 : ((FRAC_BITS+2)'(iou_q) - (FRAC_BITS+2)'(empty_q));
    assign uni_v  = malformed ? '0 : uni_d[DL-1];

    logic [OUT_W-1:0] out_data_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {iou_v, uni_v, giou_v, inv};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_ch.valid};
        end
    end

    assign out_ch.valid = vld_reg[LAT-1];
    assign out_ch.data  = out_data_reg;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("stalled result changed");
    a_no_ready_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |-> !in_ch.ready)
        else $error("input taken during stall");
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.data[0] |-> out_ch.data[FRAC_BITS+2:1] == '0)
        else $error("flagged result has nonzero giou");
endmodule
`default_nettype wire
